// ===== sv/team_pkg.sv =====
// Shared types, codes and the level function of the threshold event action monitor.
package team_pkg;

    typedef enum logic [2:0] {
        OP_UPDATE = 3'd0,
        OP_PAUSE  = 3'd1,
        OP_RESUME = 3'd2,
        OP_STOP   = 3'd3,
        OP_REARM  = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_EXEC  = 4'b0010,
        PH_DONE  = 4'b0100,
        PH_PAUSE = 4'b1000
    } t_phase;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;
    localparam logic [1:0] ST_PAUSE = 2'd3;

    localparam logic [2:0] MODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_THRESH = 3'd1;
    localparam logic [2:0] MODE_RANGE  = 3'd2;
    localparam logic [2:0] MODE_CHANGE = 3'd3;
    localparam logic [2:0] MODE_PERIOD = 3'd4;

    localparam logic [1:0] EDGE_RISE = 2'd0;
    localparam logic [1:0] EDGE_FALL = 2'd1;
    localparam logic [1:0] EDGE_BOTH = 2'd2;
    localparam logic [1:0] EDGE_NONE = 2'd3;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_EDGE     = 3'd1;
    localparam logic [2:0] REG_THRESH   = 3'd2;
    localparam logic [2:0] REG_LOWER    = 3'd3;
    localparam logic [2:0] REG_UPPER    = 3'd4;
    localparam logic [2:0] REG_STEP     = 3'd5;
    localparam logic [2:0] REG_LIMIT    = 3'd6;
    localparam logic [2:0] REG_INTERVAL = 3'd7;

    localparam logic [15:0] RST_LIMIT    = 16'd1;
    localparam logic [31:0] RST_INTERVAL = 32'd1000;

    typedef struct packed {
        logic [2:0]         mode;
        logic [1:0]         edge_sel;
        logic signed [31:0] thr;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [30:0]        min_step;
    } t_cfg;

    typedef struct packed {
        logic level;   // level of the new sample (or kept level)
        logic hit;     // edge or step condition met
    } t_det;

    // Above-threshold or in-range level; other modes keep the stored level.
    function automatic logic f_level(input logic [2:0] mode,
                                     input logic signed [31:0] s,
                                     input logic signed [31:0] thr,
                                     input logic signed [31:0] lo,
                                     input logic signed [31:0] hi,
                                     input logic keep);
        logic lvl;
        case (mode)
            MODE_THRESH: lvl = s > thr;
            MODE_RANGE:  lvl = (s >= lo) && (s <= hi);
            default:     lvl = keep;
        endcase
        return lvl;
    endfunction

endpackage

// ===== sv/team_detect.sv =====
// Condition detector: sample level, crossing edge and change step.
module team_detect
    import team_pkg::*;
(
    input  t_cfg               i_cfg,
    input  logic signed [31:0] i_sample,
    input  logic signed [31:0] i_prev,
    input  logic               i_level,
    output t_det               o_det
);

    logic               lvl;
    logic               edge_hit;
    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic               step_hit;

    assign lvl = f_level(i_cfg.mode, i_sample, i_cfg.thr, i_cfg.lo, i_cfg.hi, i_level);

    always_comb begin
        case (i_cfg.edge_sel)
            EDGE_RISE: edge_hit = lvl && !i_level;
            EDGE_FALL: edge_hit = !lvl && i_level;
            EDGE_BOTH: edge_hit = lvl != i_level;
            EDGE_NONE: edge_hit = 1'b0;
            default:   edge_hit = 1'b0;
        endcase
    end

    // exact difference on 33 bits, then magnitude
    assign diff     = $signed({i_sample[31], i_sample}) - $signed({i_prev[31], i_prev});
    assign mag      = diff[32] ? 33'(-diff) : 33'(diff);
    assign step_hit = mag >= {2'b00, i_cfg.min_step};

    assign o_det.level = lvl;
    assign o_det.hit   = (i_cfg.mode == MODE_CHANGE) ? step_hit : edge_hit;

endmodule

// ===== sv/threshold_event_action_monitor.sv =====
// Top level of the one-channel threshold event action monitor.
//
//  channel   dir  handshake          payload
//  input     in   i_valid / o_ready  i_op, i_sample_value, i_now_ms
//  result    out  o_valid / i_ready  o_action_fire, o_state_code, o_fires_so_far,
//                                    o_trigger_stamp, o_condition_level
//  config    in   psel / penable     paddr, pwdata, pwrite -> prdata, pready
//
// One item per cycle unless a stalled result holds o_ready low: each beat is evaluated
// combinationally and the monitor state and result register load at the accepting edge;
// the result shows in the next cycle. The result register frees and refills in the same
// cycle, so a stalled result blocks only while i_ready is low. Reset is synchronous;
// config writes take effect at the APB access edge.
module threshold_event_action_monitor
    import team_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_sample_value,
    input  logic [31:0]        i_now_ms,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_action_fire,
    output logic [1:0]         o_state_code,
    output logic [15:0]        o_fires_so_far,
    output logic [31:0]        o_trigger_stamp,
    output logic               o_condition_level,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg               r_cfg;
    logic [15:0]        r_limit;
    logic [31:0]        r_interval;

    t_phase             r_phase,     n_phase;
    logic [15:0]        r_fire_count, n_fire_count;
    logic [31:0]        r_last,      n_last;
    logic [31:0]        r_trig_time, n_trig_time;
    logic               r_level,     n_level;
    logic signed [31:0] r_prev,      n_prev;
    logic               r_primed,    n_primed;
    logic               r_fire,      n_fire;
    logic               r_out_valid;

    logic               in_acc;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;
    logic               cfg_level;
    logic               enabled;
    logic [31:0]        elapsed;
    logic               elapsed_ok;
    logic [15:0]        count_inc;
    t_det               det;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    assign o_ready = !r_out_valid || i_ready;
    assign in_acc  = i_valid && o_ready;

    team_detect u_detect (
        .i_cfg    (r_cfg),
        .i_sample (i_sample_value),
        .i_prev   (r_prev),
        .i_level  (r_level),
        .o_det    (det)
    );

    // level after a threshold or bound write, using the value being written
    assign cfg_level = f_level(r_cfg.mode, r_prev,
                               (cfg_idx == REG_THRESH) ? $signed(pwdata) : r_cfg.thr,
                               (cfg_idx == REG_LOWER)  ? $signed(pwdata) : r_cfg.lo,
                               (cfg_idx == REG_UPPER)  ? $signed(pwdata) : r_cfg.hi,
                               r_level);

    assign enabled    = r_cfg.mode inside {[MODE_THRESH:MODE_PERIOD]};
    assign elapsed    = i_now_ms - r_last;
    assign elapsed_ok = elapsed >= r_interval;
    assign count_inc  = r_fire_count + 16'd1;

    always_comb begin
        n_phase      = r_phase;
        n_fire_count = r_fire_count;
        n_last       = r_last;
        n_trig_time  = r_trig_time;
        n_level      = r_level;
        n_prev       = r_prev;
        n_primed     = r_primed;
        n_fire       = 1'b0;
        if (in_acc) begin
            case (t_op'(i_op))
                OP_UPDATE: begin
                    if (enabled && r_phase != PH_PAUSE) begin
                        if (r_phase == PH_EXEC) begin
                            if (elapsed_ok && r_fire_count < r_limit) begin
                                n_fire       = 1'b1;
                                n_fire_count = count_inc;
                                n_last       = i_now_ms;
                                if (r_limit != 16'd0 && count_inc >= r_limit) begin
                                    n_phase = PH_DONE;
                                end
                            end
                        end else if (!r_primed) begin
                            // first sample only sets the reference
                            n_prev   = i_sample_value;
                            n_level  = det.level;
                            n_primed = 1'b1;
                            if (r_cfg.mode == MODE_PERIOD) begin
                                n_last = i_now_ms;
                            end
                        end else begin
                            n_prev = i_sample_value;
                            if (r_cfg.mode != MODE_PERIOD && r_cfg.mode != MODE_CHANGE) begin
                                n_level = det.level;
                            end
                            if ((r_cfg.mode == MODE_PERIOD) ? elapsed_ok : det.hit) begin
                                n_trig_time  = i_now_ms;
                                n_last       = i_now_ms;
                                n_fire_count = 16'd1;
                                n_fire       = 1'b1;
                                n_phase      = (r_limit == 16'd1) ? PH_DONE : PH_EXEC;
                            end
                        end
                    end
                end
                OP_PAUSE: begin
                    if (r_phase == PH_EXEC) begin
                        n_phase = PH_PAUSE;
                    end
                end
                OP_RESUME: begin
                    if (r_phase == PH_PAUSE) begin
                        n_phase = PH_EXEC;
                        n_last  = i_now_ms;
                    end
                end
                OP_STOP: begin
                    if (r_phase == PH_EXEC || r_phase == PH_PAUSE) begin
                        n_phase = PH_DONE;
                    end
                end
                OP_REARM: begin
                    n_phase      = PH_IDLE;
                    n_fire_count = 16'd0;
                    n_prev       = i_sample_value;
                    n_level      = det.level;
                    n_primed     = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= '0;
            r_limit      <= RST_LIMIT;
            r_interval   <= RST_INTERVAL;
            r_phase      <= PH_IDLE;
            r_fire_count <= '0;
            r_last       <= '0;
            r_trig_time  <= '0;
            r_level      <= 1'b0;
            r_prev       <= '0;
            r_primed     <= 1'b0;
            r_fire       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_fire_count <= n_fire_count;
            r_last       <= n_last;
            r_trig_time  <= n_trig_time;
            r_prev       <= n_prev;
            if (in_acc) begin
                r_fire <= n_fire;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            // config writes should land only while no beat is in flight; the block itself does not enforce it
            if (cfg_wr && (cfg_idx == REG_THRESH || cfg_idx == REG_LOWER ||
                           cfg_idx == REG_UPPER)) begin
                r_level <= cfg_level;
            end else begin
                r_level <= n_level;
            end
            if (cfg_wr && cfg_idx == REG_MODE) begin
                r_primed <= 1'b0;
            end else begin
                r_primed <= n_primed;
            end
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_MODE:     r_cfg.mode     <= pwdata[2:0];
                    REG_EDGE:     r_cfg.edge_sel <= pwdata[1:0];
                    REG_THRESH:   r_cfg.thr      <= $signed(pwdata);
                    REG_LOWER:    r_cfg.lo       <= $signed(pwdata);
                    REG_UPPER:    r_cfg.hi       <= $signed(pwdata);
                    REG_STEP:     r_cfg.min_step <= pwdata[30:0];
                    REG_LIMIT:    r_limit        <= pwdata[15:0];
                    REG_INTERVAL: r_interval     <= pwdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MODE:     prdata = {29'd0, r_cfg.mode};
            REG_EDGE:     prdata = {30'd0, r_cfg.edge_sel};
            REG_THRESH:   prdata = r_cfg.thr;
            REG_LOWER:    prdata = r_cfg.lo;
            REG_UPPER:    prdata = r_cfg.hi;
            REG_STEP:     prdata = {1'b0, r_cfg.min_step};
            REG_LIMIT:    prdata = {16'd0, r_limit};
            REG_INTERVAL: prdata = r_interval;
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        case (r_phase)
            PH_IDLE:  o_state_code = ST_IDLE;
            PH_EXEC:  o_state_code = ST_EXEC;
            PH_DONE:  o_state_code = ST_DONE;
            PH_PAUSE: o_state_code = ST_PAUSE;
            default:  o_state_code = ST_IDLE;
        endcase
    end

    // state registers hold the state after the beat on display, unless a config write changes the stored level
    assign o_valid           = r_out_valid;
    assign o_action_fire     = r_fire;
    assign o_fires_so_far    = r_fire_count;
    assign o_trigger_stamp   = r_trig_time;
    assign o_condition_level = r_level;

    a_fire_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action_fire |-> o_fires_so_far != 16'd0)
        else $error("action pulse shown with zero pulse count");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(r_fire_count) && $stable(r_phase))
        else $error("monitor state moved while result stalled");

    a_pause_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_phase == PH_PAUSE |=> !o_action_fire)
        else $error("action pulse issued while paused");

    a_rearm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && t_op'(i_op) == OP_REARM |=>
            o_state_code == ST_IDLE && o_fires_so_far == 16'd0 && r_primed)
        else $error("rearm did not clear the burst");

endmodule

// ===== sim/threshold_event_action_monitor_checker.sv =====
// Scoreboard for the threshold event action monitor: tracks register writes, predicts and compares results.
module threshold_event_action_monitor_checker
    import team_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_sample_value,
    input  logic [31:0]        i_now_ms,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic               o_action_fire,
    input  logic [1:0]         o_state_code,
    input  logic [15:0]        o_fires_so_far,
    input  logic [31:0]        o_trigger_stamp,
    input  logic               o_condition_level,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 failures,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        fire;
        logic [1:0]  state;
        logic [15:0] count;
        logic [31:0] stamp;
        logic        level;
    } t_outcome;

    t_outcome expected_outcomes[$];

    // register shadow
    logic [2:0]         cfg_mode;
    logic [1:0]         cfg_edge;
    logic signed [31:0] cfg_thr;
    logic signed [31:0] cfg_lo;
    logic signed [31:0] cfg_hi;
    logic [30:0]        cfg_min_step;
    logic [15:0]        cfg_limit;
    logic [31:0]        cfg_interval;

    // monitor state
    logic [1:0]         phase_code;
    logic [15:0]        fire_count;
    logic [31:0]        last_action_ms;
    logic [31:0]        trigger_ms;
    logic               level_flag;
    logic signed [31:0] prev_sample;
    logic               primed;

    initial begin
        failures = 0;
        pending  = 0;
    end

    function automatic logic sample_level(input logic signed [31:0] s);
        if (cfg_mode == MODE_THRESH) return s > cfg_thr;
        if (cfg_mode == MODE_RANGE) return (s >= cfg_lo) && (s <= cfg_hi);
        return level_flag;
    endfunction

    task automatic reset_monitor();
        cfg_mode       = MODE_OFF;
        cfg_edge       = EDGE_RISE;
        cfg_thr        = '0;
        cfg_lo         = '0;
        cfg_hi         = '0;
        cfg_min_step   = '0;
        cfg_limit      = RST_LIMIT;
        cfg_interval   = RST_INTERVAL;
        phase_code     = ST_IDLE;
        fire_count     = '0;
        last_action_ms = '0;
        trigger_ms     = '0;
        level_flag     = 1'b0;
        prev_sample    = '0;
        primed         = 1'b0;
        expected_outcomes.delete();
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_MODE: begin
                cfg_mode = data[2:0];
                primed   = 1'b0;
            end
            REG_EDGE: cfg_edge = data[1:0];
            REG_THRESH: begin
                cfg_thr    = data;
                level_flag = sample_level(prev_sample);
            end
            REG_LOWER: begin
                cfg_lo     = data;
                level_flag = sample_level(prev_sample);
            end
            REG_UPPER: begin
                cfg_hi     = data;
                level_flag = sample_level(prev_sample);
            end
            REG_STEP:     cfg_min_step = data[30:0];
            REG_LIMIT:    cfg_limit = data[15:0];
            REG_INTERVAL: cfg_interval = data;
            default: ;
        endcase
    endtask

    task automatic advance_monitor(input t_op op, input logic signed [31:0] s,
                                   input logic [31:0] now);
        t_outcome    r;
        logic        fire;
        logic        trig;
        logic        lvl;
        logic        enabled;
        logic [31:0] since;
        logic [32:0] diff;
        logic [32:0] mag;
        fire    = 1'b0;
        enabled = (cfg_mode >= MODE_THRESH) && (cfg_mode <= MODE_PERIOD);
        since   = now - last_action_ms;
        case (op)
            OP_UPDATE: begin
                if (!enabled || phase_code == ST_PAUSE) begin
                    // ignored
                end else if (phase_code == ST_EXEC) begin
                    // burst in progress: no condition check, only the repeat timer
                    if (since >= cfg_interval && fire_count < cfg_limit) begin
                        fire           = 1'b1;
                        fire_count     = fire_count + 16'd1;
                        last_action_ms = now;
                        if (cfg_limit != 16'd0 && fire_count >= cfg_limit)
                            phase_code = ST_DONE;
                    end
                end else if (!primed) begin
                    prev_sample = s;
                    level_flag  = sample_level(s);
                    if (cfg_mode == MODE_PERIOD) last_action_ms = now;
                    primed = 1'b1;
                end else begin
                    trig = 1'b0;
                    if (cfg_mode == MODE_PERIOD) begin
                        trig = since >= cfg_interval;
                    end else if (cfg_mode == MODE_CHANGE) begin
                        // exact difference on 33 bits
                        diff = {s[31], s} - {prev_sample[31], prev_sample};
                        mag  = diff[32] ? -diff : diff;
                        trig = mag >= {2'b00, cfg_min_step};
                    end else begin
                        lvl = sample_level(s);
                        case (cfg_edge)
                            EDGE_RISE: trig = lvl && !level_flag;
                            EDGE_FALL: trig = !lvl && level_flag;
                            EDGE_BOTH: trig = lvl != level_flag;
                            default:   trig = 1'b0;
                        endcase
                        level_flag = lvl;
                    end
                    prev_sample = s;
                    if (trig) begin
                        trigger_ms     = now;
                        last_action_ms = now;
                        phase_code     = (cfg_limit == 16'd1) ? ST_DONE : ST_EXEC;
                        fire_count     = 16'd1;
                        fire           = 1'b1;
                    end
                end
            end
            OP_PAUSE: if (phase_code == ST_EXEC) phase_code = ST_PAUSE;
            OP_RESUME: begin
                if (phase_code == ST_PAUSE) begin
                    phase_code     = ST_EXEC;
                    last_action_ms = now;
                end
            end
            OP_STOP: begin
                if (phase_code == ST_EXEC || phase_code == ST_PAUSE) phase_code = ST_DONE;
            end
            OP_REARM: begin
                phase_code  = ST_IDLE;
                fire_count  = '0;
                prev_sample = s;
                level_flag  = sample_level(s);
                primed      = 1'b1;
            end
            default: ;
        endcase
        r.fire  = fire;
        r.state = phase_code;
        r.count = fire_count;
        r.stamp = trigger_ms;
        r.level = level_flag;
        expected_outcomes.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            reset_monitor();
        end else begin
            // a result leaving now belongs to an earlier beat: compare before predicting
            if (o_valid && i_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    failures++;
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("action_fire", 32'(want.fire), 32'(o_action_fire));
                    check_field("state_code", 32'(want.state), 32'(o_state_code));
                    check_field("fires_so_far", 32'(want.count), 32'(o_fires_so_far));
                    check_field("trigger_stamp", want.stamp, o_trigger_stamp);
                    check_field("condition_level", 32'(want.level),
                                32'(o_condition_level));
                end
            end
            if (psel && penable && pwrite && pready) write_register(paddr[4:2], pwdata);
            if (i_valid && o_ready) advance_monitor(t_op'(i_op), i_sample_value, i_now_ms);
        end
        pending = expected_outcomes.size();
    end

endmodule

// ===== sim/threshold_event_action_monitor_tb.sv =====
// Testbench top for the threshold event action monitor: clock, reset, stimulus and verdict.
module threshold_event_action_monitor_tb;
    import team_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    localparam int PHASES          = 16;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 5000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_op = OP_UPDATE;
    logic signed [31:0] i_sample_value = '0;
    logic [31:0]        i_now_ms = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_action_fire;
    logic [1:0]         o_state_code;
    logic [15:0]        o_fires_so_far;
    logic [31:0]        o_trigger_stamp;
    logic               o_condition_level;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int failures;
    int pending;

    int          idle_mode = IDLE_NONE;
    logic        hold_req = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_left = 0;
    int unsigned stuck_cycles = 0;

    // values the random samples are aimed at
    logic [2:0]         cur_mode;
    logic signed [31:0] cur_thr;
    logic signed [31:0] cur_lo;
    logic signed [31:0] cur_hi;
    logic [30:0]        cur_step;
    logic [15:0]        cur_limit;
    logic [31:0]        cur_interval;
    logic signed [31:0] last_sample = '0;
    logic [31:0]        clock_ms = '0;
    int unsigned        time_span = 10;

    threshold_event_action_monitor uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_op              (i_op),
        .i_sample_value    (i_sample_value),
        .i_now_ms          (i_now_ms),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_action_fire     (o_action_fire),
        .o_state_code      (o_state_code),
        .o_fires_so_far    (o_fires_so_far),
        .o_trigger_stamp   (o_trigger_stamp),
        .o_condition_level (o_condition_level),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    threshold_event_action_monitor_checker scoreboard (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_op              (i_op),
        .i_sample_value    (i_sample_value),
        .i_now_ms          (i_now_ms),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_action_fire     (o_action_fire),
        .o_state_code      (o_state_code),
        .o_fires_so_far    (o_fires_so_far),
        .o_trigger_stamp   (o_trigger_stamp),
        .o_condition_level (o_condition_level),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .failures          (failures),
        .pending           (pending)
    );

    always #1 i_clk = ~i_clk;

    // result side: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECEIVER: i_ready <= $urandom_range(99) >= 71;
                IDLE_BOTH:     i_ready <= $urandom_range(99) >= 14;
                default:       i_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pwrite)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("[threshold_event_action_monitor] ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic bit sender_rests();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(99) < 71;
            IDLE_BOTH:   return $urandom_range(99) < 14;
            default:     return 1'b0;
        endcase
    endfunction

    // setup beat now, access beat at the next falling edge; caller releases the bus
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_item(input t_op op, input logic signed [31:0] s, input logic [31:0] t);
        while (sender_rests()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_sample_value <= s;
        i_now_ms       <= t;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic pick_config(input int phase_no);
        cur_mode = (phase_no == 9) ? MODE_OFF : 3'(MODE_THRESH + (phase_no + phase_no / 4) % 4);
        case ($urandom_range(3))
            0:       cur_thr = $urandom;
            1:       cur_thr = $urandom_range(1) ? S_MAX : S_MIN;
            default: cur_thr = 32'($urandom_range(40)) - 32'sd20;
        endcase
        cur_lo = 32'($urandom_range(60)) - 32'sd40;
        cur_hi = cur_lo + 32'($urandom_range(30));
        if ($urandom_range(4) == 0) begin
            cur_lo = $urandom;
            cur_hi = $urandom;
        end
        case ($urandom_range(3))
            0:       cur_step = '0;
            1:       cur_step = 31'h7FFF_FFFF;
            2:       cur_step = 31'($urandom);
            default: cur_step = 31'($urandom_range(20));
        endcase
        case ($urandom_range(4))
            0:       cur_limit = '0;
            1:       cur_limit = 16'd1;
            2:       cur_limit = 16'hFFFF;
            default: cur_limit = 16'($urandom_range(8, 2));
        endcase
        case ($urandom_range(4))
            0:       cur_interval = '0;
            1:       cur_interval = 32'd1000;
            2:       cur_interval = 32'hFFFF_FFFF;
            default: cur_interval = 32'($urandom_range(20, 1));
        endcase
        if (phase_no == 1) begin
            cur_thr   = S_MIN;
            cur_lo    = S_MIN;
            cur_hi    = S_MAX;
            cur_limit = 16'hFFFF;
        end
        if (phase_no == 2) cur_thr = S_MAX;
        time_span = (cur_interval <= 32'd20) ? cur_interval + 3 : 600;
        apb_write(REG_MODE, 32'(cur_mode));
        apb_write(REG_EDGE, 32'($urandom_range(3)));
        apb_write(REG_THRESH, cur_thr);
        apb_write(REG_LOWER, cur_lo);
        apb_write(REG_UPPER, cur_hi);
        apb_write(REG_STEP, 32'(cur_step));
        apb_write(REG_LIMIT, 32'(cur_limit));
        apb_write(REG_INTERVAL, cur_interval);
        apb_release();
    endtask

    task automatic send_random_item();
        int unsigned        pick;
        t_op                op;
        logic signed [31:0] s;
        logic signed [31:0] jump;
        logic [31:0]        t;
        pick = $urandom_range(99);
        if (pick < 78)      op = OP_UPDATE;
        else if (pick < 84) op = OP_PAUSE;
        else if (pick < 89) op = OP_RESUME;
        else if (pick < 93) op = OP_STOP;
        else                op = OP_REARM;
        jump = 32'(cur_step) + 32'($urandom_range(2)) - 32'sd1;
        case ($urandom_range(9))
            0: s = $urandom;
            1: s = $urandom_range(1) ? S_MAX : S_MIN;
            default: begin
                // aim near the decision points so crossings happen often
                case (cur_mode)
                    MODE_THRESH: s = cur_thr + 32'($urandom_range(8)) - 32'sd4;
                    MODE_RANGE:  s = ($urandom_range(1) ? cur_lo : cur_hi)
                                     + 32'($urandom_range(8)) - 32'sd4;
                    MODE_CHANGE: s = $urandom_range(1) ? last_sample + jump
                                                       : last_sample - jump;
                    default:     s = last_sample + 32'($urandom_range(8)) - 32'sd4;
                endcase
            end
        endcase
        case ($urandom_range(19))
            0: begin
                clock_ms = $urandom;
                t = clock_ms;
            end
            1: t = clock_ms - 32'd1;
            default: begin
                clock_ms = clock_ms + 32'($urandom_range(time_span));
                t = clock_ms;
            end
        endcase
        if (op == OP_UPDATE || op == OP_REARM) last_sample = s;
        send_item(op, s, t);
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // disabled after reset: updates ignored, commands out of phase ignored, then a rearm
        send_item(OP_UPDATE, S_MAX, 32'd0);
        send_item(OP_PAUSE, 32'sd0, 32'd0);
        send_item(OP_RESUME, 32'sd0, 32'd0);
        send_item(OP_STOP, 32'sd0, 32'd0);
        send_item(OP_REARM, S_MIN, 32'hFFFF_FFFF);
        wait_drained();

        // rising threshold, three-pulse burst with pause and resume
        apb_write(REG_MODE, 32'(MODE_THRESH));
        apb_write(REG_EDGE, 32'(EDGE_RISE));
        apb_write(REG_THRESH, 32'd0);
        apb_write(REG_LIMIT, 32'd3);
        apb_write(REG_INTERVAL, 32'd10);
        apb_release();
        send_item(OP_UPDATE, -32'sd1, 32'd100);
        send_item(OP_UPDATE, S_MAX, 32'd105);
        send_item(OP_UPDATE, 32'sd0, 32'd110);
        send_item(OP_UPDATE, 32'sd0, 32'd115);
        send_item(OP_PAUSE, 32'sd0, 32'd116);
        send_item(OP_UPDATE, 32'sd0, 32'd200);
        send_item(OP_RESUME, 32'sd0, 32'd200);
        send_item(OP_UPDATE, 32'sd0, 32'd205);
        send_item(OP_UPDATE, 32'sd0, 32'd210);
        send_item(OP_STOP, 32'sd0, 32'd211);
        wait_drained();

        // range with inverted bounds, then bound writes recompute the stored level
        apb_write(REG_MODE, 32'(MODE_RANGE));
        apb_write(REG_EDGE, 32'(EDGE_BOTH));
        apb_write(REG_LOWER, 32'd10);
        apb_write(REG_UPPER, -32'sd10);
        apb_write(REG_LIMIT, 32'd0);
        apb_release();
        send_item(OP_UPDATE, 32'sd0, 32'd300);
        wait_drained();
        apb_write(REG_LOWER, -32'sd100);
        apb_write(REG_UPPER, S_MAX);
        apb_release();
        send_item(OP_UPDATE, -32'sd101, 32'd302);
        send_item(OP_UPDATE, 32'sd0, 32'd400);
        send_item(OP_STOP, 32'sd0, 32'd401);
        send_item(OP_REARM, S_MAX, 32'd402);
        wait_drained();

        // full-scale change against the largest step, zero interval
        apb_write(REG_MODE, 32'(MODE_CHANGE));
        apb_write(REG_STEP, 32'h7FFF_FFFF);
        apb_write(REG_LIMIT, 32'd2);
        apb_write(REG_INTERVAL, 32'd0);
        apb_release();
        send_item(OP_UPDATE, S_MIN, 32'd500);
        send_item(OP_UPDATE, S_MAX, 32'd500);
        send_item(OP_UPDATE, S_MAX, 32'd500);
        wait_drained();

        // period mode, elapsed time wraps to the largest interval
        apb_write(REG_MODE, 32'(MODE_PERIOD));
        apb_write(REG_LIMIT, 32'd1);
        apb_write(REG_INTERVAL, 32'hFFFF_FFFF);
        apb_release();
        send_item(OP_UPDATE, 32'sd0, 32'd5);
        send_item(OP_UPDATE, 32'sd0, 32'd4);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            pick_config(p);
            idle_mode = p % 4;
            // fill the block while results are held off
            if (p == 4) hold_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_item();
            wait_drained();
        end

        if (failures == 0) begin
            $display("[threshold_event_action_monitor] OK");
        end else begin
            $display("[threshold_event_action_monitor] ERROR");
        end
        $finish;
    end

endmodule
